[src/qbt_pkg.sv]
`default_nettype none
package qbt_pkg;

    localparam int STEPS = 10;
    localparam int DEN   = STEPS * STEPS;
    localparam int KW    = $clog2(STEPS + 1);
    localparam int WW    = $clog2(DEN + 1);
    localparam int PW    = 16 + WW + 1;
    localparam int NW    = PW + 2;
    localparam int MAG_W = 15 + WW;
    localparam int SH    = MAG_W;
    localparam int RW    = SH + 1;
    localparam logic [RW-1:0] RECIP = RW'((longint'(1) << SH) / DEN);

    typedef logic signed [15:0] coord_t;
    typedef logic [KW-1:0]      ksel_t;
    typedef logic [WW-1:0]      weight_t;

    typedef struct packed {
        coord_t [1:0] s_pt;
        coord_t [1:0] e_pt;
        coord_t [1:0] c_pt;
        ksel_t        k;
        logic         curve;
        logic         last;
        logic         cend;
    } issue_t;

endpackage
`default_nettype wire

[src/qbt_if.sv]
`default_nettype none
interface qbt_seg_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  start_x;
    logic signed [15:0]  start_y;
    logic signed [15:0]  end_x;
    logic signed [15:0]  end_y;
    logic signed [15:0]  ctrl_x;
    logic signed [15:0]  ctrl_y;
    logic                is_curve;
    logic                contour_end;

    modport source (output valid, start_x, start_y, end_x, end_y, ctrl_x, ctrl_y,
                    is_curve, contour_end, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, ctrl_x, ctrl_y,
                  is_curve, contour_end, output ready);
endinterface

interface qbt_pt_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  point_x;
    logic signed [15:0]  point_y;
    logic                last_of_segment;
    logic                contour_done;

    modport source (output valid, point_x, point_y, last_of_segment, contour_done,
                    input ready);
    modport sink (input valid, point_x, point_y, last_of_segment, contour_done,
                  output ready);
endinterface
`default_nettype wire

[src/qbt_seq.sv]
`default_nettype none
module qbt_seq (
    input  wire logic      clk,
    input  wire logic      rst_n,
    qbt_seg_if.sink        seg,
    output qbt_pkg::issue_t issue,
    output logic           issue_valid,
    input  wire logic      issue_ready
);
    import qbt_pkg::*;

    logic         busy_reg, busy_next;
    ksel_t        k_reg, k_next;
    logic [1:0]   flags_reg, flags_next;
    coord_t [1:0] s_reg, e_reg, c_reg;
    logic         fire, at_last, take;

    assign at_last     = (k_reg == KW'(STEPS - 1));
    assign fire        = busy_reg && issue_ready;
    assign seg.ready   = !busy_reg || (fire && at_last);
    assign take        = seg.valid && seg.ready;
    assign issue_valid = busy_reg;

    always_comb
    begin
        issue.s_pt  = s_reg;
        issue.e_pt  = e_reg;
        issue.c_pt  = c_reg;
        issue.k     = k_reg;
        issue.curve = flags_reg[0];
        issue.cend  = flags_reg[1];
        issue.last  = at_last;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        k_next     = k_reg;
        flags_next = flags_reg;
        priority if (take)
        begin
            busy_next  = 1'b1;
            k_next     = '0;
            flags_next = {seg.contour_end, seg.is_curve};
        end
        else if (fire && at_last)
        begin
            busy_next = 1'b0;
            k_next    = '0;
        end
        else if (fire)
        begin
            k_next = k_reg + KW'(1);
        end
        else
        begin
            k_next = k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            flags_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            k_reg     <= k_next;
            flags_reg <= flags_next;
        end
    end

    // Coordinates are payload: written on every accepted beat, never read before.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_reg <= {seg.start_y, seg.start_x};
            e_reg <= {seg.end_y, seg.end_x};
            c_reg <= {seg.ctrl_y, seg.ctrl_x};
        end
    end

endmodule
`default_nettype wire

[src/qbt_eval.sv]
`default_nettype none
module qbt_eval (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire qbt_pkg::issue_t issue,
    input  wire logic            issue_valid,
    output logic                 issue_ready,
    qbt_pt_if.source             pt
);
    import qbt_pkg::*;

    // Valid bits of the six stages.
    logic [6:1] v_reg, v_next;
    logic [6:1] adv;

    // Stage 1: blend weights.
    weight_t [2:0] w1_reg, w1_next;
    coord_t  [1:0] s1_reg, e1_reg, c1_reg;
    // Stage 2: weighted products, per axis.
    logic signed [PW-1:0] p2_reg [2][3];
    logic signed [PW-1:0] p2_next [2][3];
    // Stage 3: numerator magnitude and sign.
    logic [MAG_W-1:0] m3_reg [2];
    logic [MAG_W-1:0] m3_next [2];
    logic [1:0]       n3_reg, n3_next;
    // Stage 4: quotient estimate.
    logic [15:0]      q4_reg [2];
    logic [15:0]      q4_next [2];
    logic [MAG_W-1:0] m4_reg [2];
    logic [1:0]       n4_reg;
    // Stage 5: remainder.
    logic [15:0]      q5_reg [2];
    logic [WW:0]      r5_reg [2];
    logic [WW:0]      r5_next [2];
    logic [1:0]       n5_reg;
    // Stage 6: output register.
    coord_t [1:0]     o6_reg, o6_next;

    logic [6:1] last_reg, cend_reg;

    assign adv[6] = !v_reg[6] || pt.ready;
    assign adv[5] = !v_reg[5] || adv[6];
    assign adv[4] = !v_reg[4] || adv[5];
    assign adv[3] = !v_reg[3] || adv[4];
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign issue_ready = adv[1];

    always_comb
    begin
        v_next = v_reg;
        if (adv[1]) v_next[1] = issue_valid;
        if (adv[2]) v_next[2] = v_reg[1];
        if (adv[3]) v_next[3] = v_reg[2];
        if (adv[4]) v_next[4] = v_reg[3];
        if (adv[5]) v_next[5] = v_reg[4];
        if (adv[6]) v_next[6] = v_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // A line is blended as (e*k*S + s*r*S) / S^2, which truncates the same way as
    // (e*k + s*r) / S, so one divider by S^2 serves both kinds of segment.
    always_comb
    begin
        logic [2*KW:0] k_w, r_w, kk, rr, kr2, ks, rs;
        k_w = (2*KW+1)'(issue.k);
        r_w = (2*KW+1)'(KW'(STEPS) - issue.k);
        kk  = k_w * k_w;
        rr  = r_w * r_w;
        kr2 = (k_w * r_w) << 1;
        ks  = k_w * (2*KW+1)'(STEPS);
        rs  = r_w * (2*KW+1)'(STEPS);
        if (issue.curve)
        begin
            w1_next[0] = kk[WW-1:0];
            w1_next[1] = kr2[WW-1:0];
            w1_next[2] = rr[WW-1:0];
        end
        else
        begin
            w1_next[0] = ks[WW-1:0];
            w1_next[1] = '0;
            w1_next[2] = rs[WW-1:0];
        end
    end

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            p2_next[a][0] = PW'($signed(e1_reg[a])) * PW'($signed({1'b0, w1_reg[0]}));
            p2_next[a][1] = PW'($signed(c1_reg[a])) * PW'($signed({1'b0, w1_reg[1]}));
            p2_next[a][2] = PW'($signed(s1_reg[a])) * PW'($signed({1'b0, w1_reg[2]}));
        end
    end

    always_comb
    begin
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] pos;
        for (int a = 0; a < 2; a++)
        begin
            num = NW'(p2_reg[a][0]) + NW'(p2_reg[a][1]) + NW'(p2_reg[a][2]);
            n3_next[a] = num[NW-1];
            pos = num[NW-1] ? -num : num;
            m3_next[a] = pos[MAG_W-1:0];
        end
    end

    // The reciprocal is rounded down with SH at least the numerator width,
    // so the estimate is the true quotient or one below it.
    always_comb
    begin
        logic [MAG_W+RW-1:0] prod;
        for (int a = 0; a < 2; a++)
        begin
            prod = (MAG_W+RW)'(m3_reg[a]) * (MAG_W+RW)'(RECIP);
            q4_next[a] = prod[SH +: 16];
        end
    end

    always_comb
    begin
        logic [MAG_W:0] qd;
        logic [MAG_W:0] rem;
        for (int a = 0; a < 2; a++)
        begin
            qd  = (MAG_W+1)'(q4_reg[a]) * (MAG_W+1)'(DEN);
            rem = (MAG_W+1)'(m4_reg[a]) - qd;
            r5_next[a] = rem[WW:0];
        end
    end

    always_comb
    begin
        logic [15:0] qf;
        for (int a = 0; a < 2; a++)
        begin
            qf = (r5_reg[a] >= (WW+1)'(DEN)) ? q5_reg[a] + 16'd1 : q5_reg[a];
            o6_next[a] = n5_reg[a] ? -qf : qf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            w1_reg      <= w1_next;
            s1_reg      <= issue.s_pt;
            e1_reg      <= issue.e_pt;
            c1_reg      <= issue.c_pt;
            last_reg[1] <= issue.last;
            cend_reg[1] <= issue.cend && issue.last;
        end
        if (adv[2])
        begin
            p2_reg      <= p2_next;
            last_reg[2] <= last_reg[1];
            cend_reg[2] <= cend_reg[1];
        end
        if (adv[3])
        begin
            m3_reg      <= m3_next;
            n3_reg      <= n3_next;
            last_reg[3] <= last_reg[2];
            cend_reg[3] <= cend_reg[2];
        end
        if (adv[4])
        begin
            q4_reg      <= q4_next;
            m4_reg      <= m3_reg;
            n4_reg      <= n3_reg;
            last_reg[4] <= last_reg[3];
            cend_reg[4] <= cend_reg[3];
        end
        if (adv[5])
        begin
            q5_reg      <= q4_reg;
            r5_reg      <= r5_next;
            n5_reg      <= n4_reg;
            last_reg[5] <= last_reg[4];
            cend_reg[5] <= cend_reg[4];
        end
        if (adv[6])
        begin
            o6_reg      <= o6_next;
            last_reg[6] <= last_reg[5];
            cend_reg[6] <= cend_reg[5];
        end
    end

    assign pt.valid           = v_reg[6];
    assign pt.point_x         = o6_reg[0];
    assign pt.point_y         = o6_reg[1];
    assign pt.last_of_segment = last_reg[6];
    assign pt.contour_done    = cend_reg[6];

endmodule
`default_nettype wire

[src/quadratic_bezier_tessellator_top.sv]
// Outline segment tessellator.
// The seg channel takes one segment per beat: start, end and control points plus
// the is_curve and contour_end flags. The pt channel returns STEPS points per
// segment, sampled at t = k/STEPS for k = 0 .. STEPS-1, in order; the end point
// itself is left for the next segment. last_of_segment marks the final point of
// each segment, and contour_done repeats contour_end on that same point.
// An accepted beat passes the sequencer and the evaluation stages before its first
// point is valid. While pt.ready is high, throughput is one point per cycle; the
// sample sequencer then issues one parameter value per cycle into a single
// six-stage evaluation pipeline (weights, products, sum, reciprocal multiply,
// remainder, correction and output register). The next segment is accepted in
// the cycle its predecessor's last sample is issued, so segments run back to back.
// When pt.ready is low the pipeline fills its empty stages and then holds; no
// point is dropped or repeated. Reset (rst_n low) empties the pipeline and the
// sequencer; no point is pending afterwards.
`default_nettype none
module quadratic_bezier_tessellator_top (
    input  wire logic clk,
    input  wire logic rst_n,
    qbt_seg_if.sink   seg,
    qbt_pt_if.source  pt
);
    import qbt_pkg::*;

    issue_t issue;
    logic   issue_valid;
    logic   issue_ready;

    qbt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg         (seg),
        .issue       (issue),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready)
    );

    qbt_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .pt          (pt)
    );

endmodule
`default_nettype wire

[src/qbt_checker.sv]
`default_nettype none
module qbt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               seg_valid,
    input wire logic               seg_ready,
    input wire logic               pt_valid,
    input wire logic               pt_ready,
    input wire logic signed [15:0] point_x,
    input wire logic signed [15:0] point_y,
    input wire logic               last_of_segment,
    input wire logic               contour_done
);
    import qbt_pkg::*;

    ksel_t      pcnt_reg, pcnt_next;
    logic [7:0] pend_reg, pend_next;
    logic       seg_beat, pt_beat;

    assign seg_beat = seg_valid && seg_ready;
    assign pt_beat  = pt_valid && pt_ready;

    always_comb
    begin
        pcnt_next = pcnt_reg;
        pend_next = pend_reg;
        if (pt_beat)
        begin
            pcnt_next = last_of_segment ? '0 : pcnt_reg + KW'(1);
        end
        if (seg_beat && !(pt_beat && last_of_segment))
        begin
            pend_next = pend_reg + 8'd1;
        end
        else if (!seg_beat && pt_beat && last_of_segment)
        begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pcnt_reg <= pcnt_next;
            pend_reg <= pend_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_ready |=> pt_valid && $stable(point_x) && $stable(point_y)
            && $stable(last_of_segment) && $stable(contour_done))
        else $error("stalled point changed or was withdrawn");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        pt_beat |-> (last_of_segment == (pcnt_reg == KW'(STEPS - 1))))
        else $error("segment did not yield exactly STEPS points");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && contour_done |-> last_of_segment)
        else $error("contour_done away from the last point of a segment");

    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid |-> (pend_reg != 8'd0))
        else $error("point shown with no segment outstanding");

endmodule

bind quadratic_bezier_tessellator_top qbt_checker u_qbt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .seg_valid       (seg.valid),
    .seg_ready       (seg.ready),
    .pt_valid        (pt.valid),
    .pt_ready        (pt.ready),
    .point_x         (pt.point_x),
    .point_y         (pt.point_y),
    .last_of_segment (pt.last_of_segment),
    .contour_done    (pt.contour_done)
);
`default_nettype wire

[tb/tb_quadratic_bezier_tessellator_top.sv]
module tb_quadratic_bezier_tessellator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qbt_pkg::*;

    localparam coord_t MIN_C = 16'sh8000;
    localparam coord_t MAX_C = 16'sh7fff;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t cx;
        coord_t cy;
        logic   curve;
        logic   cend;
    } segment_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
        logic   cdone;
    } point_t;

    logic clk;
    logic rst_n;

    qbt_seg_if seg_bus ();
    qbt_pt_if  pt_bus ();

    quadratic_bezier_tessellator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_bus),
        .pt    (pt_bus)
    );

    point_t      expected_points[$];
    int unsigned fail_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned rx_pause = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Exact integer evaluation of one axis; SV signed division truncates toward zero.
    function automatic coord_t sample_axis(coord_t s, coord_t e, coord_t c, logic curve,
                                           int k);
        longint sl;
        longint el;
        longint cl;
        longint r;
        longint v;
        sl = s;
        el = e;
        cl = c;
        r  = STEPS - k;
        if (curve)
            v = (el * k * k + 2 * cl * k * r + sl * r * r) / (STEPS * STEPS);
        else
            v = (el * k + sl * r) / STEPS;
        return coord_t'(v);
    endfunction

    function automatic void predict_segment_points(segment_t s);
        point_t p;
        for (int k = 0; k < STEPS; k++)
        begin
            p.x     = sample_axis(s.sx, s.ex, s.cx, s.curve, k);
            p.y     = sample_axis(s.sy, s.ey, s.cy, s.curve, k);
            p.last  = (k == STEPS - 1);
            p.cdone = (k == STEPS - 1) ? s.cend : 1'b0;
            expected_points = {expected_points, p};
        end
    endfunction

    function automatic segment_t make_seg(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                          coord_t cx, coord_t cy, logic curve, logic cend);
        segment_t s;
        s.sx = sx;
        s.sy = sy;
        s.ex = ex;
        s.ey = ey;
        s.cx = cx;
        s.cy = cy;
        s.curve = curve;
        s.cend = cend;
        return s;
    endfunction

    // Mostly full-range values, with a share of extremes and values near zero.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: return MIN_C;
            1: return MAX_C;
            2: return coord_t'(int'($urandom_range(0, 40)) - 20);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Called just after a rising edge; returns just after the edge that accepted the beat.
    task automatic send_segment(segment_t s);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            seg_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_bus.start_x     <= s.sx;
        seg_bus.start_y     <= s.sy;
        seg_bus.end_x       <= s.ex;
        seg_bus.end_y       <= s.ey;
        seg_bus.ctrl_x      <= s.cx;
        seg_bus.ctrl_y      <= s.cy;
        seg_bus.is_curve    <= s.curve;
        seg_bus.contour_end <= s.cend;
        seg_bus.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!seg_bus.ready);
        predict_segment_points(s);
    endtask

    task automatic drain_points();
        seg_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_segment(make_seg(MIN_C, MIN_C, MAX_C, MAX_C, 0, 0, 1'b0, 1'b0));
        send_segment(make_seg(MAX_C, MAX_C, MIN_C, MIN_C, 0, 0, 1'b0, 1'b1));
        send_segment(make_seg(MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C, 1'b1, 1'b0));
        send_segment(make_seg(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 1'b1, 1'b1));
        send_segment(make_seg(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, 1'b1, 1'b0));
        send_segment(make_seg(MIN_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, 1'b1, 1'b1));
        send_segment(make_seg(MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, 1'b1, 1'b0));
        send_segment(make_seg(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        send_segment(make_seg(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    endtask

    // Negative fractions must round toward zero, not toward minus infinity.
    task automatic test_truncation();
        send_segment(make_seg(-1, -1, 0, 0, 0, 0, 1'b0, 1'b0));
        send_segment(make_seg(-7, 7, 3, -3, -5, 5, 1'b1, 1'b1));
        send_segment(make_seg(MIN_C, 1, -32767, -1, 0, 0, 1'b0, 1'b0));
        send_segment(make_seg(1, -1, -1, 1, MIN_C, MAX_C, 1'b1, 1'b0));
    endtask

    task automatic test_line_ignores_ctrl();
        send_segment(make_seg(-1234, 4321, 5678, -8765, MIN_C, MIN_C, 1'b0, 1'b0));
        send_segment(make_seg(-1234, 4321, 5678, -8765, MAX_C, MAX_C, 1'b0, 1'b1));
        send_segment(make_seg(-1234, 4321, 5678, -8765, 0, 0, 1'b0, 1'b0));
    endtask

    task automatic test_back_to_back(int unsigned count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int unsigned i = 0; i < count; i++)
            send_segment(make_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Closed contours whose segments chain end to start, with some stray segments mixed in.
    task automatic test_random_contours(int unsigned count);
        int unsigned sent;
        int unsigned len;
        bit          drained;
        coord_t      fx;
        coord_t      fy;
        coord_t      px;
        coord_t      py;
        coord_t      nx;
        coord_t      ny;
        sent = 0;
        drained = 1'b0;
        while (sent < count)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                send_segment(make_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                fx = rand_coord();
                fy = rand_coord();
                px = fx;
                py = fy;
                for (int unsigned i = 0; i < len; i++)
                begin
                    nx = (i == len - 1) ? fx : rand_coord();
                    ny = (i == len - 1) ? fy : rand_coord();
                    send_segment(make_seg(px, py, nx, ny, rand_coord(), rand_coord(),
                                          1'($urandom_range(0, 1)), i == len - 1));
                    px = nx;
                    py = ny;
                    sent++;
                end
            end
            if (!drained && sent >= count / 2)
            begin
                drain_points();
                drained = 1'b1;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Checks each point beat and sets the stall pattern of the point channel.
    always @(posedge clk)
    begin
        point_t exp_pt;
        if (rst_n && pt_bus.valid && pt_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected point beat: x %0d y %0d", pt_bus.point_x, pt_bus.point_y);
                fail_count++;
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                if (pt_bus.point_x !== exp_pt.x)
                begin
                    $error("point_x: expected %0d, got %0d", exp_pt.x, pt_bus.point_x);
                    fail_count++;
                end
                if (pt_bus.point_y !== exp_pt.y)
                begin
                    $error("point_y: expected %0d, got %0d", exp_pt.y, pt_bus.point_y);
                    fail_count++;
                end
                if (pt_bus.last_of_segment !== exp_pt.last)
                begin
                    $error("last_of_segment: expected %0b, got %0b", exp_pt.last,
                           pt_bus.last_of_segment);
                    fail_count++;
                end
                if (pt_bus.contour_done !== exp_pt.cdone)
                begin
                    $error("contour_done: expected %0b, got %0b", exp_pt.cdone,
                           pt_bus.contour_done);
                    fail_count++;
                end
            end
            rx_pause = rx_idle_on ? $urandom_range(0, 8) : 0;
        end
        if (rx_pause != 0)
        begin
            rx_pause--;
            pt_bus.ready <= 1'b0;
        end
        else
            pt_bus.ready <= 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        seg_bus.valid = 1'b0;
        seg_bus.start_x = '0;
        seg_bus.start_y = '0;
        seg_bus.end_x = '0;
        seg_bus.end_y = '0;
        seg_bus.ctrl_x = '0;
        seg_bus.ctrl_y = '0;
        seg_bus.is_curve = 1'b0;
        seg_bus.contour_end = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_truncation();
        test_line_ignores_ctrl();
        test_back_to_back(20);
        test_random_contours(110);

        drain_points();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
